// File: rtl/tlge_pkg.sv
// Shared types and constants for the toroidal life grid engine.
// No dependencies; imported by the controller, the datapath and the top level.
package tlge_pkg;

	localparam int GRID_DIM_DEF = 32;

	localparam logic [2:0] MODE_SET     = 3'd0;
	localparam logic [2:0] MODE_CLEAR   = 3'd1;
	localparam logic [2:0] MODE_ADVANCE = 3'd2;
	localparam logic [2:0] MODE_READ    = 3'd3;
	localparam logic [2:0] MODE_WIPE    = 3'd4;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_LOAD,
		OP_WRITE,
		OP_SCAN,
		OP_GEN,
		OP_DECIDE,
		OP_WIPE,
		OP_REPORT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   first;
		logic   last;
	} dp_cmd_t;

	typedef struct packed {
		logic gen_stop;
	} dp_status_t;

endpackage

// File: rtl/tlge_ctrl.sv
// Controller state machine of the life grid engine: sequences row sweeps.
// Depends on tlge_pkg; drives commands into tlge_datapath.
module tlge_ctrl #(
	parameter int GRID_DIM = tlge_pkg::GRID_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2:0]           mode,
	input  logic [7:0]           gen_count,
	input  tlge_pkg::dp_status_t status,
	output tlge_pkg::dp_cmd_t    cmd,
	output logic                 busy,
	output logic                 done
);
	import tlge_pkg::*;

	localparam int CW = $clog2(GRID_DIM);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WRITE,
		S_SCAN,
		S_GEN,
		S_DECIDE,
		S_WIPE,
		S_REPORT
	} state_t;

	state_t         state_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic           first;
	logic           last;

	assign first = (cnt_q == '0);
	assign last  = (cnt_q == CW'(GRID_DIM - 1));
	assign busy  = busy_q;
	assign done  = done_q;

	always_comb begin
		cmd.first = first;
		cmd.last  = last;
		case (state_q)
			S_IDLE:   cmd.op = (start) ? OP_LOAD : OP_IDLE;
			S_WRITE:  cmd.op = OP_WRITE;
			S_SCAN:   cmd.op = OP_SCAN;
			S_GEN:    cmd.op = OP_GEN;
			S_DECIDE: cmd.op = OP_DECIDE;
			S_WIPE:   cmd.op = OP_WIPE;
			S_REPORT: cmd.op = OP_REPORT;
			default:  cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						busy_q <= 1'b1;
						case (mode)
							MODE_SET, MODE_CLEAR: state_q <= S_WRITE;
							MODE_ADVANCE:         state_q <= (gen_count == 8'd0) ? S_REPORT : S_GEN;
							MODE_WIPE:            state_q <= S_WIPE;
							default:              state_q <= S_REPORT;
						endcase
					end
				end
				S_WRITE: begin
					cnt_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= S_REPORT;
					end
				end
				S_GEN: begin
					cnt_q <= cnt_q + 1'b1;
					if (last) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					cnt_q   <= '0;
					state_q <= (status.gen_stop) ? S_REPORT : S_GEN;
				end
				S_WIPE: begin
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/tlge_datapath.sv
// Datapath of the life grid engine: rotating row store, neighbor logic,
// counters and result registers. Depends on tlge_pkg; driven by tlge_ctrl.
module tlge_datapath #(
	parameter int GRID_DIM = tlge_pkg::GRID_DIM_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tlge_pkg::dp_cmd_t    cmd,
	input  logic [2:0]           mode,
	input  logic [4:0]           row,
	input  logic [4:0]           col,
	input  logic [7:0]           gen_count,
	output tlge_pkg::dp_status_t status,
	output logic [31:0]          row_bits,
	output logic [15:0]          generation,
	output logic [7:0]           gens_done,
	output logic                 game_over,
	output logic                 all_dead
);
	import tlge_pkg::*;

	localparam int RW = $clog2(GRID_DIM);
	localparam int OW = (GRID_DIM > 32) ? GRID_DIM : 32;

	logic [GRID_DIM-1:0] grid_q [GRID_DIM];
	logic [15:0]         count_q;
	logic                all_dead_q;
	logic [7:0]          done_cnt_q;
	logic                over_q;
	logic                chg_q;
	logic                live_q;
	logic [2:0]          mode_q;
	logic [4:0]          row_q;
	logic [4:0]          col_q;
	logic [7:0]          gens_q;
	logic [GRID_DIM-1:0] prev_q;
	logic [GRID_DIM-1:0] first_q;
	logic [31:0]         row_bits_q;
	logic [15:0]         generation_q;
	logic [7:0]          gens_done_q;
	logic                game_over_q;
	logic                all_dead_out_q;

	logic [RW-1:0]       ri;
	logic [RW-1:0]       ci;
	logic                on_row;
	logic                on_grid;
	logic [GRID_DIM-1:0] sel_row;
	logic [OW-1:0]       sel_ext;
	logic [GRID_DIM-1:0] cur;
	logic [GRID_DIM-1:0] above;
	logic [GRID_DIM-1:0] below;
	logic [GRID_DIM-1:0] next_row;
	logic                live_in;
	logic                chg_in;
	logic [7:0]          done_inc;

	assign ri      = RW'(row_q);
	assign ci      = RW'(col_q);
	assign on_row  = int'(row_q) < GRID_DIM;
	assign on_grid = on_row && (int'(col_q) < GRID_DIM);
	assign sel_row = grid_q[ri];
	assign sel_ext = OW'(sel_row);

	assign cur   = grid_q[0];
	assign above = (cmd.first) ? grid_q[GRID_DIM-1] : prev_q;
	assign below = (cmd.last) ? first_q : grid_q[1];

	always_comb begin
		logic [3:0] n;
		for (int c = 0; c < GRID_DIM; c++) begin
			n = 4'(above[(c + GRID_DIM - 1) % GRID_DIM]) + 4'(above[c])
			  + 4'(above[(c + 1) % GRID_DIM])
			  + 4'(cur[(c + GRID_DIM - 1) % GRID_DIM]) + 4'(cur[(c + 1) % GRID_DIM])
			  + 4'(below[(c + GRID_DIM - 1) % GRID_DIM]) + 4'(below[c])
			  + 4'(below[(c + 1) % GRID_DIM]);
			next_row[c] = (n == 4'd3) || (cur[c] && (n == 4'd2));
		end
	end

	assign live_in  = (cmd.first ? 1'b0 : live_q);
	assign chg_in   = (cmd.first ? 1'b0 : chg_q);
	assign done_inc = done_cnt_q + 8'd1;

	assign status.gen_stop = !chg_q || !live_q || (done_inc == gens_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < GRID_DIM; r++) begin
				grid_q[r] <= '0;
			end
			count_q    <= 16'd1;
			all_dead_q <= 1'b1;
			done_cnt_q <= '0;
			over_q     <= 1'b0;
			chg_q      <= 1'b0;
			live_q     <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					done_cnt_q <= '0;
					over_q     <= 1'b0;
				end
				OP_WRITE: begin
					if (on_grid) begin
						if (mode_q == MODE_SET && !sel_row[ci]) begin
							grid_q[ri][ci] <= 1'b1;
							count_q        <= count_q + 16'd1;
						end else if (mode_q == MODE_CLEAR && sel_row[ci]) begin
							grid_q[ri][ci] <= 1'b0;
							count_q        <= count_q + 16'd1;
						end
					end
				end
				OP_SCAN: begin
					for (int r = 0; r < GRID_DIM - 1; r++) begin
						grid_q[r] <= grid_q[r+1];
					end
					grid_q[GRID_DIM-1] <= cur;
					live_q <= live_in | (|cur);
					if (cmd.last) begin
						all_dead_q <= !(live_in | (|cur));
					end
				end
				OP_GEN: begin
					for (int r = 0; r < GRID_DIM - 1; r++) begin
						grid_q[r] <= grid_q[r+1];
					end
					grid_q[GRID_DIM-1] <= next_row;
					live_q <= live_in | (|next_row);
					chg_q  <= chg_in | (next_row != cur);
				end
				OP_DECIDE: begin
					done_cnt_q <= done_inc;
					all_dead_q <= !live_q;
					if (!chg_q || !live_q) begin
						over_q <= 1'b1;
					end else begin
						count_q <= count_q + 16'd1;
					end
				end
				OP_WIPE: begin
					for (int r = 0; r < GRID_DIM; r++) begin
						grid_q[r] <= '0;
					end
					count_q    <= 16'd1;
					all_dead_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			mode_q <= mode;
			row_q  <= row;
			col_q  <= col;
			gens_q <= gen_count;
		end
		if (cmd.op == OP_SCAN || cmd.op == OP_GEN) begin
			prev_q <= cur;
			if (cmd.first) begin
				first_q <= cur;
			end
		end
		if (cmd.op == OP_REPORT) begin
			row_bits_q     <= (on_row) ? sel_ext[31:0] : 32'd0;
			generation_q   <= count_q;
			gens_done_q    <= done_cnt_q;
			game_over_q    <= over_q;
			all_dead_out_q <= all_dead_q;
		end
	end

	assign row_bits   = row_bits_q;
	assign generation = generation_q;
	assign gens_done  = gens_done_q;
	assign game_over  = game_over_q;
	assign all_dead   = all_dead_out_q;

endmodule

// File: rtl/toroidal_life_grid_engine.sv
// Toroidal life grid engine (B3/S23). A read goes straight to the report state, a grid clear
// wipes then reports, a set/clear cell writes, scans all rows and reports, and an advance
// sweeps all rows and decides once per generation run: one row per cycle through the row store.
// One request at a time; busy falls in the cycle done is shown. Reset (arst_n):
// all cells dead, generation 1. Results cannot be stalled by the receiver.
module toroidal_life_grid_engine #(
	parameter int GRID_DIM = tlge_pkg::GRID_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  mode,
	input  logic [4:0]  row,
	input  logic [4:0]  col,
	input  logic [7:0]  gen_count,
	output logic        busy,
	output logic        done,
	output logic [31:0] row_bits,
	output logic [15:0] generation,
	output logic [7:0]  gens_done,
	output logic        game_over,
	output logic        all_dead
);
	import tlge_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	tlge_ctrl #(
		.GRID_DIM(GRID_DIM)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (mode),
		.gen_count (gen_count),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	tlge_datapath #(
		.GRID_DIM(GRID_DIM)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.mode       (mode),
		.row        (row),
		.col        (col),
		.gen_count  (gen_count),
		.status     (status),
		.row_bits   (row_bits),
		.generation (generation),
		.gens_done  (gens_done),
		.game_over  (game_over),
		.all_dead   (all_dead)
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("request accepted without busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy) else $error("done without a request in work");
	a_over_needs_gen: assert property (@(posedge clk) disable iff (!arst_n)
		done && game_over |-> gens_done != 8'd0) else $error("game over with no generation");
	a_over_means_dead_or_still: assert property (@(posedge clk) disable iff (!arst_n)
		done && gens_done != 8'd0 && !game_over |-> !all_dead)
		else $error("grid dead but game not over");
`endif

endmodule

// File: test/toroidal_life_grid_engine_test.sv
`timescale 1ns / 100ps
// Self-checking bench for toroidal_life_grid_engine: directed edge cases, then random pattern
// runs and noise, each result checked against a B3/S23 torus grid kept inside the bench.
// Depends on rtl/tlge_pkg.sv and rtl/toroidal_life_grid_engine.sv.
module toroidal_life_grid_engine_test;
	import tlge_pkg::*;

	localparam int DIM = 32;
	localparam int WATCHDOG_LIMIT = 60000;
	localparam int MAX_REPORTS = 10;

	// 5x5 shapes, bit i*5+j is row i, column j
	localparam logic [24:0] SHAPE_GLIDER = 25'd7298;
	localparam logic [24:0] SHAPE_BLINKER = 25'd224;
	localparam logic [24:0] SHAPE_BLOCK = 25'd99;
	localparam logic [24:0] SHAPE_RPENTO = 25'd2150;

	typedef struct packed {
		logic [31:0] row_bits;
		logic [15:0] generation;
		logic [7:0]  gens_done;
		logic        game_over;
		logic        all_dead;
	} life_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  mode = MODE_READ;
	logic [4:0]  row = '0;
	logic [4:0]  col = '0;
	logic [7:0]  gen_count = '0;
	logic        busy;
	logic        done;
	logic [31:0] row_bits;
	logic [15:0] generation;
	logic [7:0]  gens_done;
	logic        game_over;
	logic        all_dead;

	logic [31:0]  life_grid [DIM];
	logic [15:0]  life_generation;
	life_result_t pending_results [$];
	event         req_taken_ev;
	bit           steady_sender = 1'b0;
	int           requests_sent = 0;
	int           results_checked = 0;
	int           mismatch_count = 0;
	int           gens_total = 0;
	int           quiet_cycles = 0;

	toroidal_life_grid_engine #(.GRID_DIM(DIM)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.mode(mode),
		.row(row),
		.col(col),
		.gen_count(gen_count),
		.busy(busy),
		.done(done),
		.row_bits(row_bits),
		.generation(generation),
		.gens_done(gens_done),
		.game_over(game_over),
		.all_dead(all_dead)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void wipe_grid();
		int r;
		for (r = 0; r < DIM; r++)
			life_grid[r] = '0;
		life_generation = 16'd1;
	endfunction

	function automatic bit grid_empty();
		int r;
		for (r = 0; r < DIM; r++)
			if (life_grid[r] != '0)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic bit step_generation();
		logic [31:0] nxt [DIM];
		logic [31:0] above, here, below;
		int r, c, lc, rc, n;
		bit changed;
		changed = 1'b0;
		for (r = 0; r < DIM; r++) begin
			above = life_grid[(r + DIM - 1) % DIM];
			here = life_grid[r];
			below = life_grid[(r + 1) % DIM];
			for (c = 0; c < DIM; c++) begin
				lc = (c + DIM - 1) % DIM;
				rc = (c + 1) % DIM;
				n = int'(above[lc]) + int'(above[c]) + int'(above[rc]) + int'(here[lc])
					+ int'(here[rc]) + int'(below[lc]) + int'(below[c]) + int'(below[rc]);
				nxt[r][c] = (n == 3) || (here[c] && n == 2);
			end
		end
		for (r = 0; r < DIM; r++) begin
			if (nxt[r] != life_grid[r])
				changed = 1'b1;
			life_grid[r] = nxt[r];
		end
		return changed;
	endfunction

	function automatic life_result_t predict_request(logic [2:0] m, logic [4:0] r,
		logic [4:0] c, logic [7:0] g);
		life_result_t res;
		int applied;
		bit ended;
		bit changed;
		applied = 0;
		ended = 1'b0;
		case (m)
			MODE_SET: begin
				if (!life_grid[r][c]) begin
					life_grid[r][c] = 1'b1;
					life_generation++;
				end
			end
			MODE_CLEAR: begin
				if (life_grid[r][c]) begin
					life_grid[r][c] = 1'b0;
					life_generation++;
				end
			end
			MODE_ADVANCE: begin
				while (applied < int'(g) && !ended) begin
					changed = step_generation();
					applied++;
					if (!changed || grid_empty())
						ended = 1'b1;
					else
						life_generation++;
				end
			end
			MODE_WIPE: begin
				wipe_grid();
			end
			default: begin
			end
		endcase
		res.row_bits = life_grid[r];
		res.generation = life_generation;
		res.gens_done = applied[7:0];
		res.game_over = ended;
		res.all_dead = grid_empty();
		return res;
	endfunction

	always @(posedge clk) begin
		life_result_t seen, want;
		if (arst_n) begin
			if (done) begin
				seen = {row_bits, generation, gens_done, game_over, all_dead};
				if (pending_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$write("unexpected result: row_bits %h generation %0d gens_done %0d ",
							seen.row_bits, seen.generation, seen.gens_done);
						$display("game_over %b all_dead %b", seen.game_over, seen.all_dead);
					end
				end else begin
					want = pending_results.pop_front();
					if (seen.row_bits !== want.row_bits || seen.generation !== want.generation
						|| seen.gens_done !== want.gens_done || seen.game_over !== want.game_over
						|| seen.all_dead !== want.all_dead) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$write("result %0d differs (expected/actual): row_bits %h/%h ",
								results_checked, want.row_bits, seen.row_bits);
							$write("generation %0d/%0d gens_done %0d/%0d ", want.generation,
								seen.generation, want.gens_done, seen.gens_done);
							$display("game_over %b/%b all_dead %b/%b", want.game_over,
								seen.game_over, want.all_dead, seen.all_dead);
						end
					end
					results_checked++;
				end
			end
			if (start && !busy) begin
				want = predict_request(mode, row, col, gen_count);
				pending_results = {pending_results, want};
				gens_total += int'(want.gens_done);
				requests_sent++;
				-> req_taken_ev;
			end
			if (done || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request or result for %0d cycles", quiet_cycles);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic send_request(input logic [2:0] m, input logic [4:0] r, input logic [4:0] c,
		input logic [7:0] g);
		int gap;
		gap = steady_sender ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		mode <= m;
		row <= r;
		col <= c;
		gen_count <= g;
		@(req_taken_ev);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_gens();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 2)
			return 8'd0;
		if (roll < 5)
			return 8'($urandom_range(13, 255));
		return 8'($urandom_range(1, 12));
	endfunction

	task automatic place_shape(input logic [24:0] shape, input int base_r, input int base_c);
		int i, j;
		for (i = 0; i < 5; i++)
			for (j = 0; j < 5; j++)
				if (shape[i * 5 + j])
					send_request(MODE_SET, 5'((base_r + i) % DIM), 5'((base_c + j) % DIM),
						8'($urandom()));
	endtask

	task automatic test_cell_edits();
		send_request(MODE_READ, 5'd0, 5'd0, 8'd0);
		send_request(MODE_SET, 5'd0, 5'd0, 8'd255);
		send_request(MODE_SET, 5'd0, 5'd0, 8'd0);
		send_request(MODE_CLEAR, 5'd31, 5'd31, 8'd255);
		send_request(MODE_SET, 5'd31, 5'd31, 8'd170);
		send_request(MODE_CLEAR, 5'd31, 5'd31, 8'd85);
		send_request(MODE_READ, 5'd31, 5'd31, 8'd255);
	endtask

	task automatic test_advance_edges();
		// zero generations, lone cell dying, then an empty grid that cannot change
		send_request(MODE_ADVANCE, 5'd0, 5'd0, 8'd0);
		send_request(MODE_ADVANCE, 5'd0, 5'd17, 8'd3);
		send_request(MODE_ADVANCE, 5'd31, 5'd0, 8'd1);
	endtask

	task automatic test_still_life();
		// block split over all four corners of the torus
		send_request(MODE_SET, 5'd31, 5'd31, 8'd0);
		send_request(MODE_SET, 5'd31, 5'd0, 8'd0);
		send_request(MODE_SET, 5'd0, 5'd31, 8'd0);
		send_request(MODE_SET, 5'd0, 5'd0, 8'd0);
		send_request(MODE_ADVANCE, 5'd0, 5'd0, 8'd200);
	endtask

	task automatic test_oscillator();
		// blinker across the column wrap runs the full count without stopping
		send_request(MODE_WIPE, 5'd9, 5'd9, 8'd9);
		send_request(MODE_SET, 5'd5, 5'd31, 8'd0);
		send_request(MODE_SET, 5'd5, 5'd0, 8'd0);
		send_request(MODE_SET, 5'd5, 5'd1, 8'd0);
		send_request(MODE_ADVANCE, 5'd5, 5'd0, 8'd255);
		send_request(MODE_READ, 5'd4, 5'd0, 8'd0);
	endtask

	task automatic test_unused_modes();
		send_request(3'd5, 5'd5, 5'd0, 8'd255);
		send_request(3'd6, 5'd6, 5'd31, 8'd1);
		send_request(3'd7, 5'd4, 5'd16, 8'd128);
		send_request(MODE_WIPE, 5'd5, 5'd5, 8'd0);
	endtask

	task automatic test_pattern_runs(input int quota);
		int first, base_r, base_c, k;
		logic [24:0] shape;
		first = requests_sent;
		while (requests_sent - first < quota) begin
			steady_sender = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) != 0)
				send_request(MODE_WIPE, 5'($urandom()), 5'($urandom()), 8'($urandom()));
			base_r = $urandom_range(0, DIM - 1);
			base_c = $urandom_range(0, DIM - 1);
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 5))
					0: shape = SHAPE_GLIDER;
					1: shape = SHAPE_BLINKER;
					2: shape = SHAPE_BLOCK;
					3: shape = SHAPE_RPENTO;
					default: shape = 25'($urandom());
				endcase
				place_shape(shape, base_r + $urandom_range(0, 6), base_c + $urandom_range(0, 6));
			end
			if ($urandom_range(0, 3) == 0)
				send_request(MODE_CLEAR, 5'(base_r + $urandom_range(0, 4)),
					5'(base_c + $urandom_range(0, 4)), 8'($urandom()));
			send_request(MODE_ADVANCE, 5'(base_r + $urandom_range(0, 6)), 5'($urandom()),
				pick_gens());
			for (k = $urandom_range(1, 4); k > 0; k--)
				send_request(MODE_READ, 5'(base_r + $urandom_range(0, 10)), 5'($urandom()),
					8'($urandom()));
			if ($urandom_range(0, 2) == 0)
				send_request(MODE_ADVANCE, 5'(base_r), 5'($urandom()), pick_gens());
		end
	endtask

	task automatic test_quiet_pause();
		steady_sender = 1'b0;
		send_request(MODE_SET, 5'd12, 5'd12, 8'd0);
		send_request(MODE_SET, 5'd12, 5'd13, 8'd0);
		send_request(MODE_SET, 5'd12, 5'd14, 8'd0);
		wait_idle();
		send_request(MODE_ADVANCE, 5'd12, 5'd0, 8'd4);
		wait_idle();
		send_request(MODE_READ, 5'd11, 5'd0, 8'd0);
	endtask

	task automatic test_noise(input int quota);
		int first;
		logic [2:0] m;
		first = requests_sent;
		while (requests_sent - first < quota) begin
			if ((requests_sent - first) % 20 == 0)
				steady_sender = ($urandom_range(0, 3) == 0);
			m = 3'($urandom_range(0, 7));
			if (m == MODE_WIPE && $urandom_range(0, 3) != 0)
				m = MODE_SET;
			send_request(m, 5'($urandom()), 5'($urandom()),
				(m == MODE_ADVANCE) ? pick_gens() : 8'($urandom()));
		end
	endtask

	initial begin
		wipe_grid();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		test_cell_edits();
		test_advance_edges();
		test_still_life();
		test_oscillator();
		test_unused_modes();
		test_pattern_runs(1150);
		test_quiet_pause();
		test_noise(450);
		wait_idle();
		repeat (DIM + 8) @(posedge clk);
		$display("Run covered %0d requests and %0d checked results, %0d generations in all.",
			requests_sent, results_checked, gens_total);
		$display("Mismatches counted: %0d.", mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
